// File: rtl/core/kway_sorted_stream_merge_assert.svh
// Assertion macros used by the merge block's datapath RTL.
// Each expects signals named clk and rst_n in the enclosing scope.
`ifndef KWAY_SORTED_STREAM_MERGE_ASSERT_SVH
`define KWAY_SORTED_STREAM_MERGE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KSSM_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: implication check failed");
// Next-cycle implication, disabled during reset.
`define KSSM_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: next-cycle check failed");
`else
`define KSSM_ASSERT_IMP(label, cond, prop)
`define KSSM_ASSERT_NXT(label, cond, prop)
`endif
`endif

// File: rtl/core/kssm_pkg.sv
// Shared types and constants of the k-way sorted stream merge.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package kssm_pkg;

    // Fixed field widths of the item and result.
    localparam int VALUE_W = 32;
    localparam int WAY_W   = 2;

    // Item command codes.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the item on the input ports
        logic scan_init;  // clear the minimum search
        logic rd;         // read the head of the way under scan
        logic cmp;        // compare that head against the best so far
        logic emit;       // pop the best way and load a value result
        logic emit_ovf;   // load an overflow result
    } kssm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_ovf;     // the item on the ports is a push into a full way
        logic drain_ready;  // every way holds a value or is closed, and one holds a value
        logic scan_last;    // the way under scan is the last one
        logic out_free;     // the output register can take a result this cycle
    } kssm_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/kssm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module kssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/kssm_ctrl.sv
// Controller state machine of the k-way merge.
// Depends on kssm_pkg for the command and status structs.
`default_nettype none
module kssm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire kssm_pkg::kssm_stat_t status,
    output kssm_pkg::kssm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RD,
        ST_CMP,
        ST_EMIT,
        ST_OVF
    } state_t;

    state_t state_reg;

    // Items are taken only while no drain or overflow report is under way.
    assign in_stall = (state_reg != ST_IDLE);

    // Command decode from the current state.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:  cmd.accept    = in_valid;
            ST_CHECK: cmd.scan_init = status.drain_ready;
            ST_RD:    cmd.rd        = 1'b1;
            ST_CMP:   cmd.cmp       = 1'b1;
            ST_EMIT:  cmd.emit      = status.out_free;
            ST_OVF:   cmd.emit_ovf  = status.out_free;
            default:  cmd = '0;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= status.item_ovf ? ST_OVF : ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    state_reg <= status.drain_ready ? ST_RD : ST_IDLE;
                end
                ST_RD:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    state_reg <= status.scan_last ? ST_EMIT : ST_RD;
                end
                ST_EMIT:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_OVF:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/kssm_dp.sv
// Datapath of the k-way merge: per-way FIFO state, value RAM, minimum search
// and the output register. Depends on kssm_pkg, kssm_ram and the assert macros.
`default_nettype none
`include "kway_sorted_stream_merge_assert.svh"
module kssm_dp #(
    parameter int NUM_WAYS  = 3,
    parameter int WAY_DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                command,
    input  wire logic [kssm_pkg::WAY_W-1:0]          way,
    input  wire logic signed [kssm_pkg::VALUE_W-1:0] value,
    input  wire kssm_pkg::kssm_cmd_t                 cmd,
    output kssm_pkg::kssm_stat_t                     status,
    input  wire logic                                out_stall,
    output logic                                     out_valid,
    output logic signed [kssm_pkg::VALUE_W-1:0]      value_res,
    output logic [kssm_pkg::WAY_W-1:0]               source_way,
    output logic                                     last,
    output logic                                     overflow
);

    localparam int IDX_W     = $clog2(NUM_WAYS);
    localparam int PTR_W     = $clog2(WAY_DEPTH);
    localparam int CNT_W     = $clog2(WAY_DEPTH + 1);
    localparam int SUM_W     = PTR_W + 1;
    localparam int RAM_DEPTH = NUM_WAYS * (2 ** PTR_W);
    localparam int VW        = kssm_pkg::VALUE_W;
    localparam int WW        = kssm_pkg::WAY_W;

    // Per-way FIFO control state.
    logic [CNT_W-1:0] cnt_reg  [NUM_WAYS];
    logic [PTR_W-1:0] rptr_reg [NUM_WAYS];
    logic [NUM_WAYS-1:0] closed_reg;

    // Minimum search state.
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [VW-1:0]    best_val_reg;
    logic             found_reg;
    logic [IDX_W-1:0] item_idx_reg;

    // Output register.
    logic             out_valid_reg;
    logic [VW-1:0]    value_res_reg;
    logic [WW-1:0]    source_way_reg;
    logic             last_reg;
    logic             overflow_reg;

    logic             item_ok;
    logic [IDX_W-1:0] item_idx;
    logic [NUM_WAYS-1:0] item_hot;
    logic [NUM_WAYS-1:0] scan_hot;
    logic [NUM_WAYS-1:0] best_hot;
    logic [NUM_WAYS-1:0] nz_vec;
    logic [NUM_WAYS-1:0] full_vec;
    logic [NUM_WAYS-1:0] empty_after;
    logic [PTR_W-1:0] wpos [NUM_WAYS];
    logic [PTR_W-1:0] wpos_sel;
    logic [PTR_W-1:0] scan_rptr;
    logic             item_closed;
    logic             item_full;
    logic             push_ok;
    logic             scan_nz;
    logic             last_next;
    logic             out_free;
    logic             ram_we;
    logic [VW-1:0]    ram_rdata;

    // Item decode: range check and way index.
    assign item_ok  = ({{(32 - WW){1'b0}}, way} < 32'(NUM_WAYS));
    assign item_idx = IDX_W'(way);

    // Per-way flags and the FIFO write position of each way.
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            logic [SUM_W-1:0] sum;
            sum         = SUM_W'(rptr_reg[w]) + SUM_W'(cnt_reg[w]);
            wpos[w]     = (sum >= SUM_W'(WAY_DEPTH)) ? PTR_W'(sum - SUM_W'(WAY_DEPTH))
                                                      : PTR_W'(sum);
            item_hot[w] = item_ok && (item_idx == IDX_W'(w));
            scan_hot[w] = (scan_idx_reg == IDX_W'(w));
            best_hot[w] = (best_idx_reg == IDX_W'(w));
            nz_vec[w]   = (cnt_reg[w] != '0);
            full_vec[w] = (cnt_reg[w] == CNT_W'(WAY_DEPTH));
            empty_after[w] = best_hot[w] ? (cnt_reg[w] == CNT_W'(1)) : !nz_vec[w];
        end
    end

    // One-hot selection of the addressed way's pointers.
    always_comb
    begin
        wpos_sel  = '0;
        scan_rptr = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            wpos_sel  = wpos_sel  | (item_hot[w] ? wpos[w] : '0);
            scan_rptr = scan_rptr | (scan_hot[w] ? rptr_reg[w] : '0);
        end
    end

    assign item_closed = |(item_hot & closed_reg);
    assign item_full   = |(item_hot & full_vec);
    assign push_ok     = item_ok && (command == kssm_pkg::CMD_PUSH) && !item_closed
                         && !item_full;
    assign scan_nz     = |(scan_hot & nz_vec);
    assign last_next   = (&closed_reg) && (&empty_after);
    assign out_free    = !out_valid_reg || !out_stall;
    assign ram_we      = cmd.accept && push_ok;

    // Status to the controller.
    always_comb
    begin
        status.item_ovf    = item_ok && (command == kssm_pkg::CMD_PUSH) && !item_closed
                             && item_full;
        status.drain_ready = (|nz_vec) && (&(nz_vec | closed_reg));
        status.scan_last   = (scan_idx_reg == IDX_W'(NUM_WAYS - 1));
        status.out_free    = out_free;
    end

    // Value storage: way index in the upper address bits, slot in the lower.
    kssm_ram #(
        .WIDTH (VW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr ({item_idx, wpos_sel}),
        .wdata (value),
        .re    (cmd.rd),
        .raddr ({scan_idx_reg, scan_rptr}),
        .rdata (ram_rdata)
    );

    // Per-way counts, read pointers and closed flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                cnt_reg[w]  <= '0;
                rptr_reg[w] <= '0;
            end
            closed_reg <= '0;
        end
        else
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (cmd.accept && item_hot[w])
                begin
                    if (command == kssm_pkg::CMD_CLOSE)
                    begin
                        closed_reg[w] <= 1'b1;
                    end
                    else if (push_ok)
                    begin
                        cnt_reg[w] <= cnt_reg[w] + CNT_W'(1);
                    end
                end
                if (cmd.emit && best_hot[w])
                begin
                    cnt_reg[w]  <= cnt_reg[w] - CNT_W'(1);
                    rptr_reg[w] <= (rptr_reg[w] == PTR_W'(WAY_DEPTH - 1)) ? '0
                                   : rptr_reg[w] + PTR_W'(1);
                end
            end
        end
    end

    // Minimum search over the way heads, one way per read and compare.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            item_idx_reg <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                item_idx_reg <= item_idx;
            end
            if (cmd.scan_init)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (cmd.cmp)
            begin
                if (scan_nz && (!found_reg || ($signed(ram_rdata) < $signed(best_val_reg))))
                begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= scan_idx_reg;
                end
                if (!status.scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Best value payload follows the search without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.cmp && scan_nz && (!found_reg || ($signed(ram_rdata) < $signed(best_val_reg))))
        begin
            best_val_reg <= ram_rdata;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_ovf)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            value_res_reg  <= best_val_reg;
            source_way_reg <= WW'(best_idx_reg);
            last_reg       <= last_next;
            overflow_reg   <= 1'b0;
        end
        else if (cmd.emit_ovf)
        begin
            value_res_reg  <= '0;
            source_way_reg <= WW'(item_idx_reg);
            last_reg       <= 1'b0;
            overflow_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value_res  = $signed(value_res_reg);
    assign source_way = source_way_reg;
    assign last       = last_reg;
    assign overflow   = overflow_reg;

    // A result is only loaded when the output register can take it.
    `KSSM_ASSERT_IMP(a_emit_free, cmd.emit || cmd.emit_ovf, out_free)
    // A popped way was found by the search and still holds a value.
    `KSSM_ASSERT_IMP(a_emit_nonempty, cmd.emit, found_reg && ((nz_vec & best_hot) != '0))
    // An overflow report shows up next cycle as a flagged result.
    `KSSM_ASSERT_NXT(a_ovf_result, cmd.emit_ovf, out_valid_reg && overflow_reg && !last_reg)

endmodule
`default_nettype wire

// File: rtl/core/kway_sorted_stream_merge.sv
// Top level of the k-way sorted stream merge: controller plus datapath.
// Depends on kssm_pkg, kssm_ctrl and kssm_dp.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   input   | in_valid / in_stall    | command, way, value
//   output  | out_valid / out_stall  | value_res, source_way, last, overflow
//
// A push or close is an accept, then a drain check; an item whose way is out
// of range takes the same path. A merged value takes a drain check, a head
// search reading one way per RAM access and comparing, then an emit. An
// overflow report is an accept, then its emit. Reset clears all counts,
// pointers and closed flags at once; the value RAM needs no clearing pass.
// While the output register stalls, the next result waits in the controller.
`default_nettype none
module kway_sorted_stream_merge #(
    parameter int NUM_WAYS  = 3,
    parameter int WAY_DEPTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                command,
    input  wire logic [kssm_pkg::WAY_W-1:0]          way,
    input  wire logic signed [kssm_pkg::VALUE_W-1:0] value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [kssm_pkg::VALUE_W-1:0]      value_res,
    output logic [kssm_pkg::WAY_W-1:0]               source_way,
    output logic                                     last,
    output logic                                     overflow
);

    kssm_pkg::kssm_cmd_t  cmd;
    kssm_pkg::kssm_stat_t status;

    // Sequencing of accept, search and result loading.
    kssm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Way buffers, search and output register.
    kssm_dp #(
        .NUM_WAYS  (NUM_WAYS),
        .WAY_DEPTH (WAY_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .way        (way),
        .value      (value),
        .cmd        (cmd),
        .status     (status),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .value_res  (value_res),
        .source_way (source_way),
        .last       (last),
        .overflow   (overflow)
    );

endmodule
`default_nettype wire
